FILE: rtl/core/stp_pkg.sv
// shared types and constants of the sine test pattern pixel generator
// no dependencies
package stp_pkg;

	localparam int EXPOSURE_W  = 10;
	localparam int MODE_W      = 2;
	localparam int SIZE_W      = 4;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 10;
	localparam int PIXEL_W     = 24;
	localparam int CHAN_W      = 16;
	localparam int LANES       = 3;

	// register indexes on the config port
	localparam logic [CFG_INDEX_W-1:0] REG_EXPOSURE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MODE     = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_WIDTH    = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT   = 2'd3;

	// pixel modes; the fourth code behaves as 8-bit gray
	localparam logic [MODE_W-1:0] MODE_GRAY8  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_GRAY16 = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RGB    = 2'd2;

	localparam logic [EXPOSURE_W-1:0] EXPOSURE_RST = 10'd100;
	localparam logic [MODE_W-1:0]     MODE_RST     = MODE_RGB;
	localparam logic [SIZE_W-1:0]     WIDTH_RST    = 4'd9;
	localparam logic [SIZE_W-1:0]     HEIGHT_RST   = 4'd9;

	typedef struct packed {
		logic [EXPOSURE_W-1:0] exposure;
		logic [MODE_W-1:0]     pixel_mode;
		logic [SIZE_W-1:0]     width_log2;
		logic [SIZE_W-1:0]     height_log2;
	} cfg_t;

endpackage

FILE: rtl/core/stp_phase.sv
// stage 1: phase of each channel from position, frame phase and image size
// depends on stp_pkg
module stp_phase
	import stp_pkg::*;
#(
	parameter int CW = 9,
	parameter int PB = 10
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cfg_t                       cfg,
	input  logic                       valid_i,
	input  logic [CW-1:0]              column,
	input  logic [CW-1:0]              row,
	input  logic [2:0]                 frame_phase,
	output logic                       valid_s1,
	output logic [LANES-1:0][PB-1:0]   phase_s1
);

	localparam int XW = CW + PB + 1;
	localparam int LW = CW + PB;

	logic [XW-1:0]             col_x;
	logic [XW-1:0]             pix_full;
	logic [PB-1:0]             frame_part;
	logic [PB-1:0]             base;
	logic [LANES-1:0][LW-1:0]  line_x;
	logic [LANES-1:0][LW-1:0]  line_full;
	logic [LANES-1:0][PB-1:0]  phase;

	always_comb begin
		col_x      = XW'(column) << (PB + 1);
		pix_full   = col_x >> cfg.width_log2;
		frame_part = PB'(frame_phase) << (PB - 3);
		base       = frame_part + pix_full[PB-1:0];
		// line phase times 1, 2 and 4
		for (int l = 0; l < LANES; l++) begin
			line_x[l]    = LW'(row) << (PB - 2 + l);
			line_full[l] = line_x[l] >> cfg.height_log2;
			phase[l]     = base + line_full[l][PB-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_i) begin
			phase_s1 <= phase;
		end
	end

endmodule

FILE: rtl/core/stp_sine.sv
// stage 2: quadrant fold and quarter-wave sine table lookup
// depends on stp_pkg; table is built at elaboration
module stp_sine
	import stp_pkg::*;
#(
	parameter int PB = 10,
	parameter int F  = 14
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      valid_i,
	input  logic [LANES-1:0][PB-1:0]  phase,
	output logic                      valid_s2,
	output logic [LANES-1:0][F:0]     mag_s2,
	output logic [LANES-1:0]          neg_s2
);

	localparam int          QN          = 2 ** (PB - 2);
	localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef logic [F:0] rom_t [QN];

	// quarter-wave sine in q30 by horner on the taylor series
	function automatic logic [63:0] sine_q30(input logic [63:0] idx);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		x  = (idx * HALF_PI_Q30) >> (PB - 2);
		x2 = (x * x) >> 30;
		t  = Q30_ONE - x2 / 64'd110;
		t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
		t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
		t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
		t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
		return (x * t) >> 30;
	endfunction

	// round half up to F fraction bits, clamp at one
	function automatic logic [F:0] sine_fixed(input logic [63:0] idx);
		logic [63:0] v;
		v = (sine_q30(idx) + (64'd1 << (29 - F))) >> (30 - F);
		if (v > (64'd1 << F)) begin
			v = 64'd1 << F;
		end
		return v[F:0];
	endfunction

	function automatic rom_t build_rom();
		rom_t r;
		for (int i = 0; i < QN; i++) begin
			r[i] = sine_fixed(64'(i));
		end
		return r;
	endfunction

	localparam rom_t       SINE_ROM = build_rom();
	localparam logic [F:0] SINE_TOP = sine_fixed(64'(QN));

	logic [LANES-1:0][1:0]    quad;
	logic [LANES-1:0][PB-2:0] idx;
	logic [LANES-1:0][F:0]    mag;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			quad[l] = phase[l][PB-1:PB-2];
			idx[l]  = quad[l][0] ? ((PB-1)'(QN) - (PB-1)'(phase[l][PB-3:0]))
			                     : (PB-1)'(phase[l][PB-3:0]);
			// index at a full quarter is the peak, just past the table
			mag[l]  = idx[l][PB-2] ? SINE_TOP : SINE_ROM[idx[l][PB-3:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_i) begin
			for (int l = 0; l < LANES; l++) begin
				mag_s2[l] <= mag[l];
				neg_s2[l] <= quad[l][1];
			end
		end
	end

endmodule

FILE: rtl/core/stp_level.sv
// stages 3 to 5: pedestal plus scaled sine, exposure product, divide by 100, clamp
// depends on stp_pkg
module stp_level
	import stp_pkg::*;
#(
	parameter int F = 14
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cfg_t                        cfg,
	input  logic                        valid_i,
	input  logic [LANES-1:0][F:0]       mag,
	input  logic [LANES-1:0]            neg,
	output logic                        valid_s5,
	output logic [LANES-1:0][CHAN_W-1:0] level_s5
);

	localparam int KW      = F + 16;
	localparam int EKW     = EXPOSURE_W + KW;
	localparam int NW      = 26;
	localparam int DIV_SH  = 33;
	localparam int MW      = 27;
	localparam int QPW     = NW + MW;
	localparam int QW      = QPW - DIV_SH;
	localparam logic [MW-1:0] DIV100_MUL = 27'd85899346;

	localparam logic [KW-1:0] PED8   = KW'(127);
	localparam logic [KW-1:0] AMP8   = KW'(100);
	localparam logic [KW-1:0] PED16  = KW'(32767);
	localparam logic [KW-1:0] AMP16  = KW'(25700);
	localparam logic [QW-1:0] LIM8   = QW'(255);
	localparam logic [QW-1:0] LIM16  = QW'(65535);

	logic                        wide;
	logic                        valid_s3;
	logic                        valid_s4;
	logic [LANES-1:0][KW-1:0]    base;
	logic [LANES-1:0][KW-1:0]    swing;
	logic [LANES-1:0][KW-1:0]    k;
	logic [LANES-1:0][KW-1:0]    k_s3;
	logic [LANES-1:0][EKW-1:0]   ek;
	logic [LANES-1:0][NW-1:0]    n_s4;
	logic [LANES-1:0][QPW-1:0]   qp;
	logic [LANES-1:0][QW-1:0]    quot;
	logic [QW-1:0]               lim;
	logic [LANES-1:0][CHAN_W-1:0] level;

	assign wide = (cfg.pixel_mode == MODE_GRAY16);
	assign lim  = wide ? LIM16 : LIM8;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			// numerator over exposure is never negative
			base[l]  = (wide ? PED16 : PED8) << F;
			swing[l] = wide ? KW'(mag[l]) * AMP16 : KW'(mag[l]) * AMP8;
			k[l]     = neg[l] ? (base[l] - swing[l]) : (base[l] + swing[l]);
			ek[l]    = EKW'(cfg.exposure) * EKW'(k_s3[l]);
			// divide by 100 by reciprocal, exact below 2^30
			qp[l]    = QPW'(n_s4[l]) * QPW'(DIV100_MUL);
			quot[l]  = qp[l][DIV_SH +: QW];
			level[l] = (quot[l] > lim) ? CHAN_W'(lim) : CHAN_W'(quot[l]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s3 <= valid_i;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_i) begin
			k_s3 <= k;
		end
		if (valid_s3) begin
			for (int l = 0; l < LANES; l++) begin
				n_s4[l] <= ek[l][F +: NW];
			end
		end
		if (valid_s4) begin
			level_s5 <= level;
		end
	end

endmodule

FILE: rtl/core/sine_test_pattern_pixel.sv
// top level of the sine test pattern pixel generator
// depends on stp_pkg, stp_phase, stp_sine, stp_level
module sine_test_pattern_pixel
	import stp_pkg::*;
#(
	parameter int MAX_SIDE       = 512,
	parameter int PHASE_BITS     = 10,
	parameter int SINE_FRAC_BITS = 14
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [$clog2(MAX_SIDE)-1:0] column,
	input  logic [$clog2(MAX_SIDE)-1:0] row,
	input  logic [2:0]                 frame_phase,
	output logic                       done,
	output logic [PIXEL_W-1:0]         pixel_value,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_INDEX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data
);

	// One pixel per clock: a beat is taken on every cycle that start is high,
	// and busy never rises. Each pixel comes out of the five register stages
	// with done high for one cycle; the receiver cannot stall, so nothing backs up.
	// The five register stages are: phase sums with the size shifts, quarter
	// wave sine lookup (a constant table of 2^(PHASE_BITS-2) entries), pedestal
	// plus amplitude times sine, the exposure product, and the divide by 100
	// by reciprocal multiply with the clamp. Three lanes run side by side for
	// the RGB channels; gray modes use the first lane only. Config is written
	// through cfg_valid/cfg_ready, always ready, and must only change while no
	// pixel is in flight.

	localparam int CW = $clog2(MAX_SIDE);

	cfg_t                          cfg_q;
	logic                          accept;
	logic                          valid_s1;
	logic [LANES-1:0][PHASE_BITS-1:0] phase_s1;
	logic                          valid_s2;
	logic [LANES-1:0][SINE_FRAC_BITS:0] mag_s2;
	logic [LANES-1:0]              neg_s2;
	logic [LANES-1:0][CHAN_W-1:0]  level_s5;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.exposure    <= EXPOSURE_RST;
			cfg_q.pixel_mode  <= MODE_RST;
			cfg_q.width_log2  <= WIDTH_RST;
			cfg_q.height_log2 <= HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_EXPOSURE: cfg_q.exposure    <= cfg_data[EXPOSURE_W-1:0];
				REG_MODE:     cfg_q.pixel_mode  <= cfg_data[MODE_W-1:0];
				REG_WIDTH:    cfg_q.width_log2  <= cfg_data[SIZE_W-1:0];
				REG_HEIGHT:   cfg_q.height_log2 <= cfg_data[SIZE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// stage 1: phase per channel
	stp_phase #(
		.CW (CW),
		.PB (PHASE_BITS)
	) u_phase (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.valid_i     (accept),
		.column      (column),
		.row         (row),
		.frame_phase (frame_phase),
		.valid_s1    (valid_s1),
		.phase_s1    (phase_s1)
	);

	// stage 2: sine magnitude and sign
	stp_sine #(
		.PB (PHASE_BITS),
		.F  (SINE_FRAC_BITS)
	) u_sine (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_i  (valid_s1),
		.phase    (phase_s1),
		.valid_s2 (valid_s2),
		.mag_s2   (mag_s2),
		.neg_s2   (neg_s2)
	);

	// stages 3 to 5: channel level
	stp_level #(
		.F (SINE_FRAC_BITS)
	) u_level (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.valid_i  (valid_s2),
		.mag      (mag_s2),
		.neg      (neg_s2),
		.valid_s5 (done),
		.level_s5 (level_s5)
	);

	// red in the low byte, then green, then blue; gray is zero extended
	always_comb begin
		if (cfg_q.pixel_mode == MODE_RGB) begin
			pixel_value = {level_s5[2][7:0], level_s5[1][7:0], level_s5[0][7:0]};
		end else begin
			pixel_value = PIXEL_W'(level_s5[0]);
		end
	end

	// every accepted beat gives exactly one result at the end of the pipeline
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##5 done)
		else $error("accepted pixel did not come out after five cycles");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 5))
		else $error("result strobe without a matching input beat");

	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready && cfg_index == REG_HEIGHT)
		|=> cfg_q.height_log2 == $past(cfg_data[SIZE_W-1:0]))
		else $error("height register write lost");

endmodule
